// ----- rtl/lcdns_pkg.sv -----
// ---------------------------------------------------------------------------
// lcdns_pkg: character LCD nibble sequencer package
// Beat types, register file layout, action codes and the microcode ROM.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lcdns_pkg;

    // Display geometry
    localparam int LINE_LENGTH = 40;

    // Number display clamp
    localparam logic [13:0] NUM_MAX = 14'd9999;

    // Action codes
    localparam logic [2:0] ACT_INIT    = 3'd0;
    localparam logic [2:0] ACT_COMMAND = 3'd1;
    localparam logic [2:0] ACT_DATA    = 3'd2;
    localparam logic [2:0] ACT_GOTO    = 3'd3;
    localparam logic [2:0] ACT_NUMBER  = 3'd4;

    // Register indexes
    localparam logic [2:0] CFG_ENABLE_WAIT     = 3'd0;
    localparam logic [2:0] CFG_COMMAND_WAIT    = 3'd1;
    localparam logic [2:0] CFG_POWERUP_WAIT    = 3'd2;
    localparam logic [2:0] CFG_INIT_GAP_WAIT   = 3'd3;
    localparam logic [2:0] CFG_FUNCTION_SET    = 3'd4;
    localparam logic [2:0] CFG_DISPLAY_CONTROL = 3'd5;
    localparam logic [2:0] CFG_ENTRY_MODE      = 3'd6;

    // Fixed command bytes
    localparam logic [7:0] CMD_CLEAR = 8'h01;
    localparam logic [7:0] CMD_HOME  = 8'h80;

    // Digit position of the ones digit
    localparam logic [1:0] DIGIT_LAST = 2'd3;

    typedef struct packed {
        logic [2:0]  action;
        logic [7:0]  byte_value;
        logic [5:0]  column;
        logic        row;
        logic [13:0] number;
    } in_t;

    typedef struct packed {
        logic       reg_select;
        logic [3:0] nibble;
        logic       enable;
        logic [7:0] wait_units;
        logic       last;
    } out_t;

    typedef struct packed {
        logic [7:0] enable_wait;
        logic [7:0] command_wait;
        logic [7:0] powerup_wait;
        logic [7:0] init_gap_wait;
        logic [7:0] function_set;
        logic [7:0] display_control;
        logic [7:0] entry_mode;
    } cfg_t;

    typedef enum logic {
        SEQ_IDLE,
        SEQ_RUN
    } seq_state_t;

    // Microcode fields
    typedef enum logic [1:0] {
        NIB_CONST,
        NIB_HI,
        NIB_LO
    } nib_sel_t;

    typedef enum logic [2:0] {
        BYTE_IN,
        BYTE_FSET,
        BYTE_DCTL,
        BYTE_CLEAR,
        BYTE_EMODE,
        BYTE_HOME,
        BYTE_GOTO,
        BYTE_DIGIT
    } byte_sel_t;

    typedef enum logic [2:0] {
        WAIT_ZERO,
        WAIT_EN,
        WAIT_CMD,
        WAIT_PWR,
        WAIT_GAP
    } wait_sel_t;

    typedef enum logic [1:0] {
        OP_NEXT,
        OP_END,
        OP_LOOP
    } seq_op_t;

    // Program layout
    localparam int UCODE_DEPTH = 46;
    localparam int PC_W        = $clog2(UCODE_DEPTH);
    typedef logic [PC_W-1:0] pc_t;

    localparam pc_t PC_INIT      = pc_t'(0);
    localparam pc_t PC_INIT_CMDS = pc_t'(9);
    localparam pc_t PC_CMD       = pc_t'(29);
    localparam pc_t PC_DATA      = pc_t'(33);
    localparam pc_t PC_GOTO      = pc_t'(37);
    localparam pc_t PC_NUM       = pc_t'(41);
    localparam pc_t PC_NUM_BYTE  = pc_t'(42);

    typedef struct packed {
        logic      emit;
        logic      rs;
        nib_sel_t  nsel;
        logic [3:0] nconst;
        byte_sel_t bsel;
        logic      en;
        wait_sel_t wsel;
        logic      ld_digit;
        seq_op_t   op;
        pc_t       target;
    } ucode_t;

    typedef struct packed {
        logic [3:0]  digit;
        logic [13:0] rem;
    } digit_res_t;

    // One wake-up phase of init
    function automatic ucode_t init_word(logic [3:0] nib, logic en, wait_sel_t wsel);
        ucode_t w;
        w.emit     = 1'b1;
        w.rs       = 1'b0;
        w.nsel     = NIB_CONST;
        w.nconst   = nib;
        w.bsel     = BYTE_IN;
        w.en       = en;
        w.wsel     = wsel;
        w.ld_digit = 1'b0;
        w.op       = OP_NEXT;
        w.target   = PC_INIT;
        return w;
    endfunction

    // One of the four phases of a byte transfer
    function automatic ucode_t byte_word(logic rs, byte_sel_t bsel, logic [1:0] ph,
                                         wait_sel_t tail, seq_op_t op);
        ucode_t w;
        w.emit     = 1'b1;
        w.rs       = rs;
        w.nsel     = ph[1] ? NIB_LO : NIB_HI;
        w.nconst   = 4'h0;
        w.bsel     = bsel;
        w.en       = ~ph[0];
        w.wsel     = ph[0] ? (ph[1] ? tail : WAIT_ZERO) : WAIT_EN;
        w.ld_digit = 1'b0;
        w.op       = op;
        w.target   = PC_NUM;
        return w;
    endfunction

    // Microcode ROM
    function automatic ucode_t ucode_rom(pc_t pc);
        ucode_t    w;
        pc_t       off;
        byte_sel_t bsel;
        off = '0;
        w   = '0;
        w.op = OP_END;
        if (pc < PC_INIT_CMDS) begin
            case (pc)
                pc_t'(0): w = init_word(4'h3, 1'b0, WAIT_PWR);
                pc_t'(1): w = init_word(4'h3, 1'b1, WAIT_ZERO);
                pc_t'(2): w = init_word(4'h3, 1'b0, WAIT_GAP);
                pc_t'(3): w = init_word(4'h3, 1'b1, WAIT_ZERO);
                pc_t'(4): w = init_word(4'h3, 1'b0, WAIT_GAP);
                pc_t'(5): w = init_word(4'h3, 1'b1, WAIT_ZERO);
                pc_t'(6): w = init_word(4'h3, 1'b0, WAIT_EN);
                pc_t'(7): w = init_word(4'h2, 1'b1, WAIT_ZERO);
                default:  w = init_word(4'h2, 1'b0, WAIT_ZERO);
            endcase
        end
        else if (pc < PC_CMD) begin
            // five set-up commands, four phases each
            off = pc - PC_INIT_CMDS;
            case (off[4:2])
                3'd0:    bsel = BYTE_FSET;
                3'd1:    bsel = BYTE_DCTL;
                3'd2:    bsel = BYTE_CLEAR;
                3'd3:    bsel = BYTE_EMODE;
                default: bsel = BYTE_HOME;
            endcase
            w = byte_word(1'b0, bsel, off[1:0], WAIT_CMD,
                          (pc == PC_CMD - pc_t'(1)) ? OP_END : OP_NEXT);
        end
        else if (pc < PC_NUM) begin
            // single byte programs: command, data, goto
            off = pc - PC_CMD;
            case (off[3:2])
                2'd0:    w = byte_word(1'b0, BYTE_IN, off[1:0], WAIT_ZERO, OP_NEXT);
                2'd1:    w = byte_word(1'b1, BYTE_IN, off[1:0], WAIT_ZERO, OP_NEXT);
                default: w = byte_word(1'b0, BYTE_GOTO, off[1:0], WAIT_ZERO, OP_NEXT);
            endcase
            if (off[1:0] == 2'd3) begin
                w.op = OP_END;
            end
        end
        else if (pc == PC_NUM) begin
            // split off the next decimal digit
            w          = '0;
            w.ld_digit = 1'b1;
            w.op       = OP_NEXT;
            w.target   = PC_NUM;
        end
        else if (pc < pc_t'(UCODE_DEPTH)) begin
            off = pc - PC_NUM_BYTE;
            w = byte_word(1'b1, BYTE_DIGIT, off[1:0], WAIT_ZERO,
                          (off[1:0] == 2'd3) ? OP_LOOP : OP_NEXT);
        end
        return w;
    endfunction

    // Program entry point of each action
    function automatic pc_t entry_pc(logic [2:0] action);
        pc_t pc;
        case (action)
            ACT_COMMAND: pc = PC_CMD;
            ACT_DATA:    pc = PC_DATA;
            ACT_GOTO:    pc = PC_GOTO;
            ACT_NUMBER:  pc = PC_NUM;
            default:     pc = PC_INIT;
        endcase
        return pc;
    endfunction

    // One decimal digit: compare against the multiples of the place value
    function automatic digit_res_t digit_step(logic [13:0] rem, logic [1:0] idx);
        logic [13:0] scale;
        logic [13:0] thr;
        digit_res_t  r;
        case (idx)
            2'd0:    scale = 14'd1000;
            2'd1:    scale = 14'd100;
            2'd2:    scale = 14'd10;
            default: scale = 14'd1;
        endcase
        r.digit = 4'd0;
        r.rem   = rem;
        for (int k = 1; k <= 9; k++) begin
            thr = 14'(k) * scale;
            if (rem >= thr) begin
                r.digit = 4'(k);
                r.rem   = rem - thr;
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/lcdns_cfg_regs.sv -----
// ---------------------------------------------------------------------------
// lcdns_cfg_regs: configuration register file
// Seven 8-bit registers written by index; writes beyond the list are dropped.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lcdns_cfg_regs
    import lcdns_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       wr_en,
    input  wire logic [2:0] wr_index,
    input  wire logic [7:0] wr_data,
    output cfg_t            cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // register write decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (wr_index)
                CFG_ENABLE_WAIT:     cfg_next.enable_wait     = wr_data;
                CFG_COMMAND_WAIT:    cfg_next.command_wait    = wr_data;
                CFG_POWERUP_WAIT:    cfg_next.powerup_wait    = wr_data;
                CFG_INIT_GAP_WAIT:   cfg_next.init_gap_wait   = wr_data;
                CFG_FUNCTION_SET:    cfg_next.function_set    = wr_data;
                CFG_DISPLAY_CONTROL: cfg_next.display_control = wr_data;
                CFG_ENTRY_MODE:      cfg_next.entry_mode      = wr_data;
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.enable_wait     <= 8'd2;
            cfg_reg.command_wait    <= 8'd250;
            cfg_reg.powerup_wait    <= 8'd40;
            cfg_reg.init_gap_wait   <= 8'd5;
            cfg_reg.function_set    <= 8'h28;
            cfg_reg.display_control <= 8'h0E;
            cfg_reg.entry_mode      <= 8'h06;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ----- rtl/char_lcd_nibble_sequencer_unit.sv -----
// ---------------------------------------------------------------------------
// char_lcd_nibble_sequencer_unit: character LCD 4-bit bus sequencer
// Turns each action request into a list of bus phases, driven by a
// microcoded step counter over a read-only control program.
// ---------------------------------------------------------------------------
//   channel | direction | handshake             | beat
//   in      | input     | in_valid / in_ready   | in_t: one action request
//   out     | output    | out_valid / out_ready | out_t: one bus phase
//   cfg     | input     | cfg_valid / cfg_ready | register index + 8-bit data
//
// One control word per cycle; every word that emits a phase waits for a
// free output register. Init sends the wake-up phases and five set-up commands,
// command/data/goto one byte, number a digit split word and four phases per
// digit. Goto off the line and unknown actions finish in the cycle they are
// taken. A new request is taken once the last phase of the previous one has
// been loaded into the output register. Reset restores the register defaults.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module char_lcd_nibble_sequencer_unit
    import lcdns_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire in_t        in_data,
    output logic            out_valid,
    input  wire logic       out_ready,
    output out_t            out_data,
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [2:0] cfg_index,
    input  wire logic [7:0] cfg_data
);

    cfg_t       cfg;
    seq_state_t state_reg;
    seq_state_t state_next;
    pc_t        pc_reg;
    pc_t        pc_next;
    logic [1:0] idx_reg;
    logic [1:0] idx_next;
    logic [13:0] rem_reg;
    logic [13:0] rem_next;
    logic [3:0] digit_reg;
    logic [3:0] digit_next;
    in_t        item_reg;
    in_t        item_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    out_t       out_data_reg;
    out_t       out_data_next;

    ucode_t     word;
    digit_res_t dres;
    logic       running;
    logic       accept;
    logic       start_ok;
    logic       out_free;
    logic       step;
    logic       end_now;
    logic [7:0] byte_mux;
    logic [3:0] nib_mux;
    logic [7:0] wait_mux;

    // register file
    assign cfg_ready = 1'b1;

    lcdns_cfg_regs u_cfg_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // control word and handshake
    assign word     = ucode_rom(pc_reg);
    assign accept   = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;
    assign step     = running && (!word.emit || out_free);
    assign end_now  = (word.op == OP_END) ||
                      ((word.op == OP_LOOP) && (idx_reg == DIGIT_LAST));

    // requests that produce at least one phase
    always_comb
    begin
        case (in_data.action)
            ACT_INIT,
            ACT_COMMAND,
            ACT_DATA,
            ACT_NUMBER: start_ok = accept;
            ACT_GOTO:   start_ok = accept &&
                                   ({1'b0, in_data.column} < 7'(LINE_LENGTH));
            default:    start_ok = 1'b0;
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            SEQ_IDLE:
            begin
                if (start_ok)
                begin
                    state_next = SEQ_RUN;
                end
            end
            SEQ_RUN:
            begin
                if (step && end_now)
                begin
                    state_next = SEQ_IDLE;
                end
            end
            default: state_next = SEQ_IDLE;
        endcase
    end

    // state outputs
    always_comb
    begin
        case (state_reg)
            SEQ_IDLE:
            begin
                in_ready = 1'b1;
                running  = 1'b0;
            end
            SEQ_RUN:
            begin
                in_ready = 1'b0;
                running  = 1'b1;
            end
            default:
            begin
                in_ready = 1'b0;
                running  = 1'b0;
            end
        endcase
    end

    // step counter and loop index
    always_comb
    begin
        pc_next  = pc_reg;
        idx_next = idx_reg;
        if (accept)
        begin
            pc_next  = entry_pc(in_data.action);
            idx_next = 2'd0;
        end
        else if (step)
        begin
            if ((word.op == OP_LOOP) && (idx_reg != DIGIT_LAST))
            begin
                pc_next = word.target;
            end
            else
            begin
                pc_next = pc_reg + pc_t'(1);
            end
            if (word.op == OP_LOOP)
            begin
                idx_next = idx_reg + 2'd1;
            end
        end
    end

    // item latch and digit split
    assign dres = digit_step(rem_reg, idx_reg);

    always_comb
    begin
        item_next  = item_reg;
        rem_next   = rem_reg;
        digit_next = digit_reg;
        if (accept)
        begin
            item_next = in_data;
            rem_next  = (in_data.number > NUM_MAX) ? NUM_MAX : in_data.number;
        end
        else if (step && word.ld_digit)
        begin
            rem_next   = dres.rem;
            digit_next = dres.digit;
        end
    end

    // byte source
    always_comb
    begin
        case (word.bsel)
            BYTE_IN:    byte_mux = item_reg.byte_value;
            BYTE_FSET:  byte_mux = cfg.function_set;
            BYTE_DCTL:  byte_mux = cfg.display_control;
            BYTE_CLEAR: byte_mux = CMD_CLEAR;
            BYTE_EMODE: byte_mux = cfg.entry_mode;
            BYTE_HOME:  byte_mux = CMD_HOME;
            BYTE_GOTO:  byte_mux = {1'b1, item_reg.row, item_reg.column};
            BYTE_DIGIT: byte_mux = {4'h3, digit_reg};
            default:    byte_mux = 8'h00;
        endcase
    end

    // nibble source
    always_comb
    begin
        case (word.nsel)
            NIB_CONST: nib_mux = word.nconst;
            NIB_HI:    nib_mux = byte_mux[7:4];
            NIB_LO:    nib_mux = byte_mux[3:0];
            default:   nib_mux = word.nconst;
        endcase
    end

    // wait source
    always_comb
    begin
        case (word.wsel)
            WAIT_ZERO: wait_mux = 8'd0;
            WAIT_EN:   wait_mux = cfg.enable_wait;
            WAIT_CMD:  wait_mux = cfg.command_wait;
            WAIT_PWR:  wait_mux = cfg.powerup_wait;
            WAIT_GAP:  wait_mux = cfg.init_gap_wait;
            default:   wait_mux = 8'd0;
        endcase
    end

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (step && word.emit)
        begin
            out_valid_next            = 1'b1;
            out_data_next.reg_select  = word.rs;
            out_data_next.nibble      = nib_mux;
            out_data_next.enable      = word.en;
            out_data_next.wait_units  = wait_mux;
            out_data_next.last        = end_now;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= SEQ_IDLE;
            pc_reg        <= PC_INIT;
            idx_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pc_reg        <= pc_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        item_reg     <= item_next;
        rem_reg      <= rem_next;
        digit_reg    <= digit_next;
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

// ----- rtl/lcdns_checker.sv -----
// ---------------------------------------------------------------------------
// lcdns_checker: port-level checks for the LCD nibble sequencer
// Watches the top-level ports only; attached by the bind below.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lcdns_checker
    import lcdns_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic in_valid,
    input wire logic in_ready,
    input wire in_t  in_data,
    input wire logic out_valid,
    input wire logic out_ready,
    input wire out_t out_data
);

    // a stalled beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("output beat changed while stalled");

    // actions that always produce phases keep the sequencer busy
    a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready &&
        (in_data.action == ACT_INIT || in_data.action == ACT_COMMAND ||
         in_data.action == ACT_DATA || in_data.action == ACT_NUMBER)
        |=> !in_ready)
        else $error("sequencer idle right after a producing request");

    // no phase appears from an idle sequencer
    a_no_spurious_beat: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready && !in_valid && !out_valid |=> !out_valid)
        else $error("phase produced with no request");

    // every request that produces phases ends on an enable-low phase
    a_last_enable_low: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.enable |-> !out_data.last)
        else $error("last phase has enable high");

endmodule

bind char_lcd_nibble_sequencer_unit lcdns_checker u_lcdns_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

`default_nettype wire
